[rtl/core/block_pid_delta_varint_encoder_core_macros.svh]
// Assertion macros for the block pid delta varint encoder core.
// Included by the top level; depends on nothing else.
`ifndef BLOCK_PID_DELTA_VARINT_ENCODER_CORE_MACROS_SVH
`define BLOCK_PID_DELTA_VARINT_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPDV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpdv assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BPDV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpdv assertion failed");

`endif

[rtl/core/bpdv_pkg.sv]
// Shared constants and types of the block pid delta varint encoder.
// Used by the serializer and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bpdv_pkg;

  localparam int unsigned KeyBits        = 64;
  localparam int unsigned RunBits        = 32;
  localparam int unsigned ByteBits       = 8;
  localparam int unsigned GroupBits      = 7;
  localparam int unsigned HalfKeyBitsDef = 32;

  typedef enum logic [1:0] {
    FldHead,
    FldBlock,
    FldPattern,
    FldRun
  } field_e;

  typedef struct packed {
    logic busy;
    logic finish;
  } ser_status_t;

endpackage

`default_nettype wire

[rtl/core/bpdv_serializer.sv]
// Varint serializer: turns one prepared run into LSB-first 7-bit groups, one byte per cycle while out_ready_i allows.
// Depends on bpdv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpdv_serializer #(
  parameter int unsigned HALF_KEY_BITS = bpdv_pkg::HalfKeyBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                ld_valid_i,
  output logic                                     ld_ready_o,
  input  wire logic                                ld_changed_i,
  input  wire logic [HALF_KEY_BITS-1:0]            ld_block_i,
  input  wire logic [HALF_KEY_BITS-1:0]            ld_pattern_i,
  input  wire logic [HALF_KEY_BITS:0]              ld_zz_i,
  input  wire logic [bpdv_pkg::RunBits-1:0]        ld_run_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [bpdv_pkg::ByteBits-1:0]            out_byte_o,
  output logic                                     last_o,
  output bpdv_pkg::ser_status_t                    status_o
);

  localparam int unsigned ValW = (HALF_KEY_BITS + 1 > bpdv_pkg::RunBits) ?
                                 HALF_KEY_BITS + 1 : bpdv_pkg::RunBits;
  localparam int unsigned GrpW = bpdv_pkg::GroupBits;

  bpdv_pkg::field_e fld_q, fld_d;
  logic busy_q, busy_d;
  logic [ValW-1:0] val_q, val_d;
  logic changed_q, changed_d;
  logic [HALF_KEY_BITS-1:0] blk_q, blk_d;
  logic [HALF_KEY_BITS-1:0] pat_q, pat_d;
  logic [bpdv_pkg::RunBits-1:0] run_q, run_d;
  logic out_valid_q, out_valid_d;
  logic [bpdv_pkg::ByteBits-1:0] out_byte_q, out_byte_d;
  logic out_last_q, out_last_d;

  logic emit;
  logic more;
  logic fin;
  logic load;

  always_comb begin
    emit = busy_q && (!out_valid_q || out_ready_i);
    more = |val_q[ValW-1:GrpW];
    fin  = emit && (fld_q == bpdv_pkg::FldRun) && !more;
    ld_ready_o = !busy_q || fin;
    load = ld_valid_i && ld_ready_o;

    fld_d       = fld_q;
    busy_d      = busy_q;
    val_d       = val_q;
    changed_d   = changed_q;
    blk_d       = blk_q;
    pat_d       = pat_q;
    run_d       = run_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = {more, val_q[GrpW-1:0]};
      out_last_d  = (fld_q == bpdv_pkg::FldRun) && !more;
      if (more) begin
        val_d = val_q >> GrpW;
      end else begin
        unique case (fld_q)
          bpdv_pkg::FldHead: begin
            if (changed_q) begin
              fld_d = bpdv_pkg::FldBlock;
              val_d = ValW'(blk_q);
            end else begin
              fld_d = bpdv_pkg::FldRun;
              val_d = ValW'(run_q);
            end
          end
          bpdv_pkg::FldBlock: begin
            fld_d = bpdv_pkg::FldPattern;
            val_d = ValW'(pat_q);
          end
          bpdv_pkg::FldPattern: begin
            fld_d = bpdv_pkg::FldRun;
            val_d = ValW'(run_q);
          end
          bpdv_pkg::FldRun: begin
            busy_d = 1'b0;
          end
          default: begin
            busy_d = 1'b0;
          end
        endcase
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      busy_d    = 1'b1;
      fld_d     = bpdv_pkg::FldHead;
      val_d     = ld_changed_i ? '0 : ValW'(ld_zz_i);
      changed_d = ld_changed_i;
      blk_d     = ld_block_i;
      pat_d     = ld_pattern_i;
      run_d     = ld_run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q       <= bpdv_pkg::FldHead;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fld_q       <= fld_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    changed_q  <= changed_d;
    blk_q      <= blk_d;
    pat_q      <= pat_d;
    run_q      <= run_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_o          = out_last_q;
  assign status_o.busy   = busy_q;
  assign status_o.finish = fin;

endmodule

`default_nettype wire

[rtl/core/block_pid_delta_varint_encoder_core.sv]
// Each run is sent as 2 to 10 output bytes when the block id is unchanged and 4 to 16
// when it changes, one byte per cycle from the serializer's output register unless
// out_ready_i stalls it. A run is taken into an input register while the previous one is still being
// sent, so runs follow each other without gaps. The first run after reset always starts
// a new block. Depends on bpdv_pkg, bpdv_serializer and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "block_pid_delta_varint_encoder_core_macros.svh"

module block_pid_delta_varint_encoder_core #(
  parameter int unsigned HALF_KEY_BITS = bpdv_pkg::HalfKeyBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [bpdv_pkg::KeyBits-1:0]     mapped_value_i,
  input  wire logic [bpdv_pkg::RunBits-1:0]     run_length_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [bpdv_pkg::ByteBits-1:0]         out_byte_o,
  output logic                                  last_of_item_o
);

  logic [HALF_KEY_BITS-1:0] last_block_q, prev_pattern_q;
  logic [HALF_KEY_BITS-1:0] in_block, in_pattern, diff;
  logic in_changed, in_lower;
  logic accept;

  logic ib_valid_q, ib_valid_d;
  logic ib_changed_q;
  logic [HALF_KEY_BITS-1:0] ib_block_q, ib_pattern_q;
  logic [HALF_KEY_BITS:0] ib_zz_q;
  logic [bpdv_pkg::RunBits-1:0] ib_run_q;

  logic ld_ready;
  bpdv_pkg::ser_status_t ser_status;

  always_comb begin
    in_block   = mapped_value_i[2*HALF_KEY_BITS-1:HALF_KEY_BITS];
    in_pattern = mapped_value_i[HALF_KEY_BITS-1:0];
    in_changed = (&last_block_q) || (in_block != last_block_q);
    in_lower   = in_pattern < prev_pattern_q;
    diff       = in_lower ? (prev_pattern_q - in_pattern) : (in_pattern - prev_pattern_q);
    in_ready_o = !ib_valid_q || ld_ready;
    accept     = in_valid_i && in_ready_o;
    ib_valid_d = accept || (ib_valid_q && !ld_ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_block_q   <= '1;
      prev_pattern_q <= '0;
      ib_valid_q     <= 1'b0;
    end else begin
      ib_valid_q <= ib_valid_d;
      if (accept) begin
        last_block_q   <= in_block;
        prev_pattern_q <= in_pattern;
      end
    end
  end

  // The zigzag code plus one is the magnitude with the sign flag inverted below it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ib_changed_q <= in_changed;
      ib_block_q   <= in_block;
      ib_pattern_q <= in_pattern;
      ib_zz_q      <= {diff, !in_lower};
      ib_run_q     <= run_length_i;
    end
  end

  bpdv_serializer #(
    .HALF_KEY_BITS(HALF_KEY_BITS)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_valid_i  (ib_valid_q),
    .ld_ready_o  (ld_ready),
    .ld_changed_i(ib_changed_q),
    .ld_block_i  (ib_block_q),
    .ld_pattern_i(ib_pattern_q),
    .ld_zz_i     (ib_zz_q),
    .ld_run_i    (ib_run_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_of_item_o),
    .status_o    (ser_status)
  );

  `BPDV_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, ib_valid_q && ld_ready, ser_status.busy)
  `BPDV_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, !in_ready_o,
                    ib_valid_q && ser_status.busy && !ser_status.finish)
  `BPDV_ASSERT_NEXT(a_last_block, clk_i, rst_ni, accept,
                    last_block_q == $past(in_block))

endmodule

`default_nettype wire
